>>> rtl/mpeg_audio_header_sync_detect_top_assert.svh
// Assertion macros for the MPEG audio header sync detector.
// Included by modules that check their own logic; no other dependencies.
`ifndef MPEG_AUDIO_HEADER_SYNC_DETECT_TOP_ASSERT_SVH
`define MPEG_AUDIO_HEADER_SYNC_DETECT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define MAHSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define MAHSD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MAHSD_ASSERT(lbl, prop, msg)
`define MAHSD_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/mahsd_pkg.sv
// Package for the MPEG audio header sync detector: field codes, stage types and
// the sample-rate and bitrate tables. No dependencies.
`default_nettype none
package mahsd_pkg;

	localparam logic [10:0] SYNC_PATTERN   = 11'h7ff;
	localparam logic [1:0]  MODE_SINGLE_CH = 2'd3;
	localparam logic [1:0]  LCODE_RESERVED = 2'd0;
	localparam logic [3:0]  BIDX_FREE      = 4'd0;
	localparam logic [3:0]  BIDX_BAD       = 4'd15;
	localparam logic [3:0]  BIDX_MAX_V25   = 4'd8;
	localparam logic [1:0]  SIDX_RESERVED  = 2'd3;
	localparam logic [1:0]  LAYER_III      = 2'd3;
	localparam logic [1:0]  BYTES_FULL     = 2'd3;
	localparam logic [9:0]  KBPS_SCALE     = 10'd1000;

	typedef enum logic [1:0] {
		VER_MPEG1  = 2'd0,
		VER_MPEG2  = 2'd1,
		VER_MPEG25 = 2'd2
	} ver_t;

	// Window stage payload
	typedef struct packed {
		logic [31:0] win;
		logic        full;
		logic        restart;
	} s1_t;

	// Decoded header fields
	typedef struct packed {
		logic        valid;
		logic [1:0]  version;
		logic [1:0]  layer;
		logic [1:0]  channels;
		logic [15:0] sample_rate;
		logic [18:0] bitrate;
	} hdr_t;

	// Sample rate in hertz by version and rate index
	function automatic logic [15:0] rate_lookup(input ver_t ver, input logic [1:0] sidx);
		logic [15:0] r;
		r = 16'd0;
		unique case (ver)
			VER_MPEG1: begin
				unique case (sidx)
					2'd0: r = 16'd44100;
					2'd1: r = 16'd48000;
					2'd2: r = 16'd32000;
					default: r = 16'd0;
				endcase
			end
			VER_MPEG2: begin
				unique case (sidx)
					2'd0: r = 16'd22050;
					2'd1: r = 16'd24000;
					2'd2: r = 16'd16000;
					default: r = 16'd0;
				endcase
			end
			VER_MPEG25: begin
				unique case (sidx)
					2'd0: r = 16'd11025;
					2'd1: r = 16'd12000;
					2'd2: r = 16'd8000;
					default: r = 16'd0;
				endcase
			end
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// Bitrate in kbps by version group, layer and bitrate index
	function automatic logic [8:0] kbps_lookup(input logic grp, input logic [1:0] layer,
			input logic [3:0] bidx);
		logic [8:0] k;
		k = 9'd0;
		if (!grp && layer == 2'd1) begin
			unique case (bidx)
				4'd1: k = 9'd32;   4'd2: k = 9'd64;   4'd3: k = 9'd96;
				4'd4: k = 9'd128;  4'd5: k = 9'd160;  4'd6: k = 9'd192;
				4'd7: k = 9'd224;  4'd8: k = 9'd256;  4'd9: k = 9'd288;
				4'd10: k = 9'd320; 4'd11: k = 9'd352; 4'd12: k = 9'd384;
				4'd13: k = 9'd416; 4'd14: k = 9'd448;
				default: k = 9'd0;
			endcase
		end else if (!grp && layer == 2'd2) begin
			unique case (bidx)
				4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;
				4'd4: k = 9'd64;   4'd5: k = 9'd80;   4'd6: k = 9'd96;
				4'd7: k = 9'd112;  4'd8: k = 9'd128;  4'd9: k = 9'd160;
				4'd10: k = 9'd192; 4'd11: k = 9'd224; 4'd12: k = 9'd256;
				4'd13: k = 9'd320; 4'd14: k = 9'd384;
				default: k = 9'd0;
			endcase
		end else if (!grp) begin
			unique case (bidx)
				4'd1: k = 9'd32;   4'd2: k = 9'd40;   4'd3: k = 9'd48;
				4'd4: k = 9'd56;   4'd5: k = 9'd64;   4'd6: k = 9'd80;
				4'd7: k = 9'd96;   4'd8: k = 9'd112;  4'd9: k = 9'd128;
				4'd10: k = 9'd160; 4'd11: k = 9'd192; 4'd12: k = 9'd224;
				4'd13: k = 9'd256; 4'd14: k = 9'd320;
				default: k = 9'd0;
			endcase
		end else if (layer == 2'd1) begin
			unique case (bidx)
				4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;
				4'd4: k = 9'd64;   4'd5: k = 9'd80;   4'd6: k = 9'd96;
				4'd7: k = 9'd112;  4'd8: k = 9'd128;  4'd9: k = 9'd144;
				4'd10: k = 9'd160; 4'd11: k = 9'd176; 4'd12: k = 9'd192;
				4'd13: k = 9'd224; 4'd14: k = 9'd256;
				default: k = 9'd0;
			endcase
		end else begin
			// Layers II and III share one table in the lower-rate versions
			unique case (bidx)
				4'd1: k = 9'd8;    4'd2: k = 9'd16;   4'd3: k = 9'd24;
				4'd4: k = 9'd32;   4'd5: k = 9'd40;   4'd6: k = 9'd48;
				4'd7: k = 9'd56;   4'd8: k = 9'd64;   4'd9: k = 9'd80;
				4'd10: k = 9'd96;  4'd11: k = 9'd112; 4'd12: k = 9'd128;
				4'd13: k = 9'd144; 4'd14: k = 9'd160;
				default: k = 9'd0;
			endcase
		end
		return k;
	endfunction

endpackage
`default_nettype wire

>>> rtl/mpeg_audio_header_sync_detect_top.sv
// MPEG audio header sync detector: one result per payload byte.
// A result is offered once its byte has passed two register stages: the stage-one register, then the output register.
// Throughput: one byte per cycle; s_tready falls only while both stages hold and m_tready is low.
// Reset clears window, byte count, taken flag and valid flags; payload registers are not reset.
// Depends on mahsd_pkg, mahsd_window, mahsd_decode and the assertion header.
`default_nettype none
`include "mpeg_audio_header_sync_detect_top_assert.svh"
module mpeg_audio_header_sync_detect_top
	import mahsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] restart
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [1:0] mpeg_version, [3:2] layer, [5:4] channels,
	                                    // [21:6] sample_rate, [40:22] bitrate, [47:41] zero
	output logic             m_tuser    // [0] found
);

	s1_t         s1;
	logic        valid_s1;
	hdr_t        hdr;
	logic        in_accept;
	logic        advance;
	logic        taken_q;
	logic        taken_eff;
	logic        found_now;
	logic        m_tvalid_q;
	logic        found_q;
	logic [47:0] tdata_q;

	// Handshake: stage one moves on whenever the output register is free or drains
	always_comb begin
		advance   = valid_s1 && (!m_tvalid_q || m_tready);
		s_tready  = !valid_s1 || advance;
		in_accept = s_tvalid && s_tready;
	end

	mahsd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.restart   (s_tuser),
		.in_accept (in_accept),
		.advance   (advance),
		.s1        (s1),
		.valid_s1  (valid_s1)
	);

	mahsd_decode u_decode (
		.win  (s1.win),
		.full (s1.full),
		.hdr  (hdr)
	);

	// Report only the first valid header since restart
	always_comb begin
		taken_eff = s1.restart ? 1'b0 : taken_q;
		found_now = hdr.valid && !taken_eff;
	end

	// Taken flag follows items as they enter the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
		end else if (advance) begin
			taken_q <= taken_eff || found_now;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload, zero when nothing is found
	always_ff @(posedge clk) begin
		if (advance) begin
			found_q <= found_now;
			tdata_q <= found_now ? {7'd0, hdr.bitrate, hdr.sample_rate, hdr.channels,
				hdr.layer, hdr.version} : 48'd0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = found_q;

	`MAHSD_ASSERT(a_found_fields, (m_tvalid && m_tuser) |-> (m_tdata[3:2] != 2'd0 && m_tdata[21:6] != 16'd0 && m_tdata[40:22] != 19'd0), "found result with empty fields")
	`MAHSD_ASSERT(a_idle_zero, (m_tvalid && !m_tuser) |-> (m_tdata == 48'd0), "fields set without found")
	`MAHSD_ASSERT(a_taken_src, $rose(taken_q) |-> $past(advance && found_now), "taken flag set without a found header")
	`MAHSD_ASSERT(a_ready_free, !m_tvalid |-> s_tready, "input stalled while output register empty")

endmodule
`default_nettype wire

>>> rtl/mahsd_window.sv
// Input stage: sliding 32-bit byte window, byte count and stage-one register.
// Depends on mahsd_pkg.
`default_nettype none
module mahsd_window
	import mahsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       restart,
	input  wire logic       in_accept,
	input  wire logic       advance,
	output s1_t             s1,
	output logic            valid_s1
);

	logic [23:0] recent_q;
	logic [1:0]  seen_q;
	logic [23:0] hist;
	logic [1:0]  seen_eff;
	logic [31:0] win;
	s1_t         s1_s1;

	// Restart drops history before this byte enters the window
	always_comb begin
		hist     = restart ? 24'd0 : recent_q;
		seen_eff = restart ? 2'd0 : seen_q;
		win      = {hist, data_byte};
	end

	// Advance window and saturating byte count on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= 24'd0;
			seen_q   <= 2'd0;
		end else if (in_accept) begin
			recent_q <= win[23:0];
			seen_q   <= (seen_eff == BYTES_FULL) ? BYTES_FULL : seen_eff + 2'd1;
		end
	end

	// Stage-one valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage-one payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_s1.win     <= win;
			s1_s1.full    <= (seen_eff == BYTES_FULL);
			s1_s1.restart <= restart;
		end
	end

	assign s1 = s1_s1;

endmodule
`default_nettype wire

>>> rtl/mahsd_decode.sv
// Header check and field decode of one 32-bit window, purely combinational.
// Depends on mahsd_pkg.
`default_nettype none
module mahsd_decode
	import mahsd_pkg::*;
(
	input  wire logic [31:0] win,
	input  wire logic        full,
	output hdr_t             hdr
);

	logic        ext;
	logic        id;
	logic [1:0]  lcode;
	logic [3:0]  bidx;
	logic [1:0]  sidx;
	logic [1:0]  mode;
	logic [1:0]  layer;
	logic        v25_bad;
	ver_t        ver;
	logic [8:0]  kbps;

	// Split window into header fields
	always_comb begin
		ext   = win[20];
		id    = win[19];
		lcode = win[18:17];
		bidx  = win[15:12];
		sidx  = win[11:10];
		mode  = win[7:6];
		layer = 2'(3'd4 - {1'b0, lcode});
	end

	// Validate and decode
	always_comb begin
		v25_bad = !ext && (layer != LAYER_III || id || bidx > BIDX_MAX_V25);
		ver     = id ? VER_MPEG1 : (ext ? VER_MPEG2 : VER_MPEG25);
		kbps    = kbps_lookup(ver != VER_MPEG1, layer, bidx);

		hdr.valid       = full && win[31:21] == SYNC_PATTERN && lcode != LCODE_RESERVED
			&& bidx != BIDX_FREE && bidx != BIDX_BAD && sidx != SIDX_RESERVED && !v25_bad;
		hdr.version     = ver;
		hdr.layer       = layer;
		hdr.channels    = (mode == MODE_SINGLE_CH) ? 2'd1 : 2'd2;
		hdr.sample_rate = rate_lookup(ver, sidx);
		hdr.bitrate     = 19'(kbps) * 19'(KBPS_SCALE);
	end

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for the MPEG audio header sync detector: byte streams with embedded headers,
// restarts and noise, random stalls on both streams and one long output hold-off.
// Depends on mahsd_pkg and mpeg_audio_header_sync_detect_top.

class sync_header_tracker;
	// Sample rate in hertz by version and rate index
	int unsigned rate_hz [3][3] = '{
		'{44100, 48000, 32000},
		'{22050, 24000, 16000},
		'{11025, 12000, 8000}
	};
	// kbps by version group (MPEG-1 or lower-rate), layer and bitrate index
	int unsigned kbps [2][3][15] = '{
		'{
			'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
			'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
			'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320}
		},
		'{
			'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
			'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160},
			'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
		}
	};

	logic [23:0] recent;
	logic [1:0]  seen;
	logic        taken;
	mahsd_pkg::hdr_t pending_hdrs [$];
	int unsigned bytes_noted;
	int unsigned results_checked;
	int unsigned headers_by_ver [3];
	int unsigned errors;

	function new();
		recent = '0;
		seen = '0;
		taken = 1'b0;
		bytes_noted = 0;
		results_checked = 0;
		errors = 0;
		foreach (headers_by_ver[i]) headers_by_ver[i] = 0;
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 10) $display("[%0t] error %0d: %s", $realtime, errors, msg);
	endfunction

	// Advance the window by one accepted byte and queue the expected result
	function void note_byte(logic [7:0] data_byte, logic restart);
		logic [31:0] win;
		logic [1:0]  lcode;
		logic [3:0]  bidx;
		logic [1:0]  sidx;
		logic [1:0]  layer_n;
		logic        legal;
		mahsd_pkg::ver_t ver;
		mahsd_pkg::hdr_t exp_hdr;
		if (restart) begin
			recent = '0;
			seen = '0;
			taken = 1'b0;
		end
		win = {recent, data_byte};
		lcode = win[18:17];
		bidx = win[15:12];
		sidx = win[11:10];
		layer_n = 2'(3'd4 - {1'b0, lcode});
		legal = seen == mahsd_pkg::BYTES_FULL
			&& win[31:21] == mahsd_pkg::SYNC_PATTERN
			&& lcode != mahsd_pkg::LCODE_RESERVED
			&& bidx != mahsd_pkg::BIDX_FREE && bidx != mahsd_pkg::BIDX_BAD
			&& sidx != mahsd_pkg::SIDX_RESERVED
			&& !(!win[20] && (layer_n != mahsd_pkg::LAYER_III || win[19]
				|| bidx > mahsd_pkg::BIDX_MAX_V25));
		exp_hdr = '0;
		if (legal && !taken) begin
			ver = win[19] ? mahsd_pkg::VER_MPEG1
				: (win[20] ? mahsd_pkg::VER_MPEG2 : mahsd_pkg::VER_MPEG25);
			exp_hdr.valid = 1'b1;
			exp_hdr.version = ver;
			exp_hdr.layer = layer_n;
			exp_hdr.channels = (win[7:6] == mahsd_pkg::MODE_SINGLE_CH) ? 2'd1 : 2'd2;
			exp_hdr.sample_rate = 16'(rate_hz[int'(ver)][int'(sidx)]);
			exp_hdr.bitrate = 19'(kbps[ver != mahsd_pkg::VER_MPEG1][int'(layer_n) - 1]
				[int'(bidx)] * 1000);
			headers_by_ver[int'(ver)]++;
			taken = 1'b1;
		end
		recent = win[23:0];
		if (seen != mahsd_pkg::BYTES_FULL) seen++;
		bytes_noted++;
		pending_hdrs.push_back(exp_hdr);
	endfunction

	// Compare one result transfer with the oldest expectation
	function void check_result(logic [47:0] tdata, logic tuser);
		mahsd_pkg::hdr_t exp_hdr;
		results_checked++;
		if (pending_hdrs.size() == 0) begin
			flag($sformatf("result with nothing expected: found=%0b tdata=%h", tuser, tdata));
			return;
		end
		exp_hdr = pending_hdrs.pop_front();
		if (tuser !== exp_hdr.valid || tdata[1:0] !== exp_hdr.version
				|| tdata[3:2] !== exp_hdr.layer || tdata[5:4] !== exp_hdr.channels
				|| tdata[21:6] !== exp_hdr.sample_rate || tdata[40:22] !== exp_hdr.bitrate
				|| tdata[47:41] !== 7'd0)
			flag($sformatf({"result %0d: expected found=%0b ver=%0d layer=%0d ch=%0d ",
				"rate=%0d bps=%0d pad=0, got found=%0b ver=%0d layer=%0d ch=%0d ",
				"rate=%0d bps=%0d pad=%h"}, results_checked,
				exp_hdr.valid, exp_hdr.version, exp_hdr.layer, exp_hdr.channels,
				exp_hdr.sample_rate, exp_hdr.bitrate, tuser, tdata[1:0], tdata[3:2],
				tdata[5:4], tdata[21:6], tdata[40:22], tdata[47:41]));
	endfunction

	function int unsigned pending();
		return pending_hdrs.size();
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mahsd_pkg::*;

	localparam int unsigned ITEMS        = 800;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam logic [1:0]  LCODE_LAYER3 = 2'd1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;

	sync_header_tracker tracker;
	int unsigned sent_items;
	int unsigned cycles;
	bit          steady;
	bit          long_hold_req;
	bit          long_hold_seen;

	mpeg_audio_header_sync_detect_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Random byte biased toward 0xFF to form partial sync patterns
	function automatic logic [7:0] noise_byte();
		return ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 255));
	endfunction

	// Header word with sync; mostly legal fields, the rest left random
	function automatic logic [31:0] make_header();
		logic [31:0] w;
		w = $urandom();
		w[31:21] = SYNC_PATTERN;
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 2))
				0: begin
					w[20:19] = 2'b11;
				end
				1: begin
					w[20:19] = 2'b10;
				end
				default: begin
					w[20:19] = 2'b00;
					w[18:17] = LCODE_LAYER3;
				end
			endcase
			if (w[18:17] == LCODE_RESERVED) w[18:17] = 2'($urandom_range(1, 3));
			w[15:12] = w[20] ? 4'($urandom_range(1, 14)) : 4'($urandom_range(1, 8));
			if (w[11:10] == SIDX_RESERVED) w[11:10] = 2'($urandom_range(0, 2));
		end
		return w;
	endfunction

	// Offer one byte after an optional gap and hold it until the transfer
	task automatic send_byte(input logic [7:0] data_byte, input logic restart);
		int unsigned idle;
		idle = steady ? 0 : pick_gap();
		repeat (idle) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= data_byte;
		s_tuser <= restart;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
	endtask

	// Payload runs: restart, noise, one or more headers with trailing bytes
	task automatic send_payloads(input int unsigned budget);
		logic [31:0] hdr;
		int unsigned stop;
		bit          lead;
		stop = sent_items + budget;
		while (sent_items < stop) begin
			if ($urandom_range(0, 6) == 0) begin
				send_byte(noise_byte(), $urandom_range(0, 9) == 0);
			end else begin
				lead = $urandom_range(0, 2) == 0;
				if (!lead) begin
					send_byte(noise_byte(), 1'b1);
					repeat ($urandom_range(0, 5)) send_byte(noise_byte(), 1'b0);
				end
				repeat ($urandom_range(1, 3)) begin
					hdr = make_header();
					for (int i = 3; i >= 0; i--)
						send_byte(hdr[i*8 +: 8], (i == 3 && lead)
							|| (i != 3 && $urandom_range(0, 29) == 0));
					lead = 1'b0;
					repeat ($urandom_range(0, 4)) send_byte(noise_byte(), 1'b0);
				end
			end
		end
	endtask

	// Note accepted bytes and check accepted results
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) tracker.note_byte(s_tdata, s_tuser);
		if (arst_n && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
	end

	// Output side: random stalls, steady stretches, one long hold-off on request
	initial begin : rx_drive
		int unsigned stall;
		stall = 0;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				long_hold_seen = 1'b1;
				m_tready <= 1'b1;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			tracker.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		tracker = new();
		sent_items = 0;
		steady = 1'b0;
		long_hold_req = 1'b0;
		long_hold_seen = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// MPEG-1 layer III 128k 44.1k stereo, then a second header suppressed
		send_byte(8'hff, 1'b1); send_byte(8'hfb, 1'b0);
		send_byte(8'h90, 1'b0); send_byte(8'h64, 1'b0);
		send_byte(8'hff, 1'b0); send_byte(8'hfb, 1'b0);
		send_byte(8'h90, 1'b0); send_byte(8'hc4, 1'b0);
		// restart byte closes a would-be header window
		send_byte(8'hc0, 1'b1);
		// MPEG-2.5 layer III, top index 8, 8 kHz mono
		send_byte(8'hff, 1'b0); send_byte(8'he3, 1'b0);
		send_byte(8'h88, 1'b0); send_byte(8'hc0, 1'b0);
		// the restart byte 00 leaves no sync ahead of the bad bitrate index, then MPEG-2 layer I 256k 16k mono
		send_byte(8'h00, 1'b1); send_byte(8'hfb, 1'b0);
		send_byte(8'hf0, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0); send_byte(8'hf7, 1'b0);
		send_byte(8'he8, 1'b0); send_byte(8'hff, 1'b0);
		// MPEG-1 layer I 448k 48k, starting on the restart byte
		send_byte(8'hff, 1'b1); send_byte(8'hff, 1'b0);
		send_byte(8'he4, 1'b0); send_byte(8'h00, 1'b0);

		// Random payloads with a long output hold and two gap-free stretches
		send_payloads(250);
		steady = 1'b1;
		long_hold_req = 1'b1;
		send_payloads(60);
		steady = 1'b0;
		send_payloads(200);
		steady = 1'b1;
		send_payloads(100);
		steady = 1'b0;
		if (sent_items < ITEMS) send_payloads(ITEMS - sent_items);
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain, then allow for anything late
		while (tracker.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d bytes sent, %0d results checked; first headers: MPEG-1 %0d, MPEG-2 %0d,",
			tracker.bytes_noted, tracker.results_checked, tracker.headers_by_ver[0],
			tracker.headers_by_ver[1]);
		$display("  MPEG-2.5 %0d; long output hold %0s, %0d errors",
			tracker.headers_by_ver[2], long_hold_seen ? "done" : "missed", tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
